>>> hw/rtl/cbc_pkg.sv
// cartridge bank controller package: opcodes, register indexes, handshake
// command struct and sizing constants shared by the controller and datapath
// no dependencies
package cbc_pkg;

    localparam int CBC_RAM_BYTES        = 32768;
    localparam int CBC_ROM_ADDRESS_BITS = 21;

    localparam int CBC_ROM_ADDR_W  = 21;
    localparam int CBC_S_TDATA_W   = 24;
    localparam int CBC_M_TDATA_W   = 32;
    localparam int CBC_CFG_INDEX_W = 1;
    localparam int CBC_CFG_DATA_W  = 8;

    typedef enum logic [1:0] {
        OP_ROM_READ  = 2'd0,
        OP_CTRL_WR   = 2'd1,
        OP_RAM_READ  = 2'd2,
        OP_RAM_WRITE = 2'd3
    } opcode_t;

    typedef enum logic [CBC_CFG_INDEX_W-1:0] {
        REG_ROM_BANK_COUNT = 1'b0,
        REG_RAM_SIZE_CODE  = 1'b1
    } cfg_reg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } cbc_cmd_t;

    // external ram size in bytes for the size code
    function automatic logic [16:0] ram_size_bytes(input logic [1:0] code);
        logic [16:0] size;
        begin
            unique case (code)
                2'd0:    size = 17'd0;
                2'd1:    size = 17'd2048;
                2'd2:    size = 17'd8192;
                default: size = 17'd32768;
            endcase
            return size;
        end
    endfunction

endpackage

>>> hw/rtl/cartridge_bank_controller_core.sv
// cartridge bank controller: single bus accesses in, translated rom address,
// ram read data and range error out; the slave stream carries one access per
// transfer and the master stream one result per access.
// slave side: tuser = opcode (0 rom read, 1 control write, 2 ram read,
// 3 ram write); tdata = bus address and write byte.
// master side: tdata = read byte, physical rom address, range error flag.
// config port: cfg_write with cfg_index 0 (rom bank count) or 1 (ram size
// code) loads cfg_data at the clock edge; write only while no access is open.
// the sequencer runs accept, execute and respond steps; a result is presented
// once the respond step loads the output register, and that step waits while
// the output is stalled. the internal ram is a single port memory with a
// registered read, which sets the execute step.
// reset sets rom bank 1, ram bank 0, ram disabled, mode 0, 128 rom banks and
// a 32 KB ram size; ram contents are undefined until written.
// when the receiver stalls, the last result holds in the output register; one
// further access may be accepted and executed, then s_tready stays low until
// the output register drains.
// depends on cbc_pkg, cbc_ctrl, cbc_datapath
module cartridge_bank_controller_core
    import cbc_pkg::*;
#(
    parameter int RAM_BYTES        = CBC_RAM_BYTES,
    parameter int ROM_ADDRESS_BITS = CBC_ROM_ADDRESS_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [CBC_S_TDATA_W-1:0]   s_tdata,   // bus_address[15:0], write_data[23:16]
    input  logic [1:0]                 s_tuser,   // opcode[1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [CBC_M_TDATA_W-1:0]   m_tdata,   // read_data[7:0], rom_address[28:8],
                                                  // range_error[29], zero[31:30]
    input  logic                       cfg_write,
    input  logic [CBC_CFG_INDEX_W-1:0] cfg_index,
    input  logic [CBC_CFG_DATA_W-1:0]  cfg_data
);

    cbc_cmd_t                  cmd;
    logic [7:0]                read_data;
    logic [CBC_ROM_ADDR_W-1:0] rom_address;
    logic                      range_error;

    cbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cbc_datapath #(
        .RAM_BYTES        (RAM_BYTES),
        .ROM_ADDRESS_BITS (ROM_ADDRESS_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_opcode   (s_tuser),
        .in_address  (s_tdata[15:0]),
        .in_wdata    (s_tdata[23:16]),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .read_data   (read_data),
        .rom_address (rom_address),
        .range_error (range_error)
    );

    assign m_tdata = {2'b00, range_error, rom_address, read_data};

endmodule

>>> hw/rtl/cbc_ctrl.sv
// cartridge bank controller sequencer: input/output handshake and the
// accept, execute, respond sequence; depends on cbc_pkg
module cbc_ctrl
    import cbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output cbc_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free     = !m_tvalid_reg || m_tready;
    assign cmd.load_in  = s_tvalid && s_tready_reg;
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.load_out = (state_reg == ST_RESP) && out_free;

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    s_tready_reg <= !cmd.load_in;
                    if (cmd.load_in)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    // wait for the output register to drain
                    if (out_free)
                    begin
                        s_tready_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready_reg |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == ST_EXEC && !s_tready_reg)
        else $error("accepted item did not start execution");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid_reg && s_tready_reg)
        else $error("result load did not present output");

endmodule

>>> hw/rtl/cbc_datapath.sv
// cartridge bank controller datapath: config and bank registers, rom address
// translation, range checks, internal ram and output register; depends on cbc_pkg
module cbc_datapath
    import cbc_pkg::*;
#(
    parameter int RAM_BYTES        = CBC_RAM_BYTES,
    parameter int ROM_ADDRESS_BITS = CBC_ROM_ADDRESS_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cbc_cmd_t                   cmd,
    input  logic [1:0]                 in_opcode,
    input  logic [15:0]                in_address,
    input  logic [7:0]                 in_wdata,
    input  logic                       cfg_write,
    input  logic [CBC_CFG_INDEX_W-1:0] cfg_index,
    input  logic [CBC_CFG_DATA_W-1:0]  cfg_data,
    output logic [7:0]                 read_data,
    output logic [CBC_ROM_ADDR_W-1:0]  rom_address,
    output logic                       range_error
);

    localparam int          RAM_AW    = $clog2(RAM_BYTES);
    localparam logic [16:0] RAM_LIMIT = 17'(RAM_BYTES);

    // control write regions, from bus_address[14:13]
    localparam logic [1:0] RGN_RAM_ENABLE = 2'd0;
    localparam logic [1:0] RGN_ROM_LOW    = 2'd1;
    localparam logic [1:0] RGN_UPPER      = 2'd2;
    localparam logic [1:0] RGN_MODE       = 2'd3;

    localparam logic [7:0]  RAM_ENABLE_KEY = 8'h0A;
    localparam logic [15:0] BANK_SPAN      = 16'h4000;

    // captured item
    opcode_t     op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wdata_reg;

    // configuration
    logic [7:0]  rom_bank_count_reg;
    logic [1:0]  ram_size_code_reg;

    // banking state
    logic [6:0]  rom_bank_reg;
    logic [1:0]  ram_bank_reg;
    logic        ram_enabled_reg;
    logic        banking_mode_reg;

    // result staging
    logic [CBC_ROM_ADDR_W-1:0] res_ra_reg;
    logic                      res_err_reg;
    logic                      rd_ok_reg;
    logic [7:0]                ram_q_reg;

    logic [7:0]                out_rd_reg;
    logic [CBC_ROM_ADDR_W-1:0] out_ra_reg;
    logic                      out_err_reg;

    logic [7:0] ram_mem [RAM_BYTES];

    // rom and ram address translation
    logic [21:0] rom_phys;
    logic        rom_err;
    logic [16:0] ram_limit;
    logic [15:0] ram_phys;
    logic        ram_in_range;
    logic        ram_access;
    logic        ctrl_ok;
    logic [4:0]  low_bits;
    logic [RAM_AW-1:0] ram_idx;

    always_comb
    begin
        if (addr_reg >= BANK_SPAN)
        begin
            rom_phys = {1'b0, rom_bank_reg, 14'd0} + {6'd0, addr_reg - BANK_SPAN};
        end
        else
        begin
            rom_phys = {6'd0, addr_reg};
        end
        rom_err = addr_reg[15]
               || (rom_phys >= {rom_bank_count_reg, 14'd0})
               || (rom_phys[21:ROM_ADDRESS_BITS] != '0);
    end

    always_comb
    begin
        ram_limit = ram_size_bytes(ram_size_code_reg);
        if (ram_limit > RAM_LIMIT)
        begin
            ram_limit = RAM_LIMIT;
        end
    end

    assign ram_phys     = {1'b0, ram_bank_reg, 13'd0} + {3'd0, addr_reg[12:0]};
    assign ram_in_range = (addr_reg[15:13] == 3'd0) && ({1'b0, ram_phys} < ram_limit);
    assign ram_access   = cmd.exec && (op_reg == OP_RAM_READ || op_reg == OP_RAM_WRITE)
                       && ram_enabled_reg;
    assign ram_idx      = ram_phys[RAM_AW-1:0];
    assign ctrl_ok      = cmd.exec && (op_reg == OP_CTRL_WR) && !addr_reg[15];
    assign low_bits     = (wdata_reg[4:0] == 5'd0) ? 5'd1 : wdata_reg[4:0];

    // payload registers and memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= opcode_t'(in_opcode);
            addr_reg  <= in_address;
            wdata_reg <= in_wdata;
        end
        if (ram_access && ram_in_range && op_reg == OP_RAM_WRITE)
        begin
            ram_mem[ram_idx] <= wdata_reg;
        end
        ram_q_reg <= ram_mem[ram_idx];
        if (cmd.exec)
        begin
            res_ra_reg <= (op_reg == OP_ROM_READ)
                        ? CBC_ROM_ADDR_W'(rom_phys[ROM_ADDRESS_BITS-1:0]) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_count_reg <= 8'd128;
            ram_size_code_reg  <= 2'd3;
            rom_bank_reg       <= 7'd1;
            ram_bank_reg       <= 2'd0;
            ram_enabled_reg    <= 1'b0;
            banking_mode_reg   <= 1'b0;
            res_err_reg        <= 1'b0;
            rd_ok_reg          <= 1'b0;
            out_rd_reg         <= '0;
            out_ra_reg         <= '0;
            out_err_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ROM_BANK_COUNT: rom_bank_count_reg <= cfg_data;
                    REG_RAM_SIZE_CODE:  ram_size_code_reg  <= cfg_data[1:0];
                    default:            ;
                endcase
            end

            if (ctrl_ok)
            begin
                unique case (addr_reg[14:13])
                    RGN_RAM_ENABLE:
                    begin
                        if (banking_mode_reg)
                        begin
                            ram_enabled_reg <= (wdata_reg == RAM_ENABLE_KEY);
                        end
                    end
                    RGN_ROM_LOW:
                    begin
                        rom_bank_reg[4:0] <= low_bits;
                    end
                    RGN_UPPER:
                    begin
                        if (banking_mode_reg)
                        begin
                            ram_bank_reg <= wdata_reg[1:0];
                        end
                        else
                        begin
                            rom_bank_reg[6:5] <= wdata_reg[1:0];
                        end
                    end
                    RGN_MODE:
                    begin
                        banking_mode_reg <= wdata_reg[0];
                    end
                    default: ;
                endcase
            end

            if (cmd.exec)
            begin
                rd_ok_reg <= ram_access && ram_in_range && (op_reg == OP_RAM_READ);
                unique case (op_reg)
                    OP_ROM_READ:  res_err_reg <= rom_err;
                    OP_CTRL_WR:   res_err_reg <= addr_reg[15];
                    default:      res_err_reg <= ram_enabled_reg && !ram_in_range;
                endcase
            end

            if (cmd.load_out)
            begin
                out_rd_reg  <= rd_ok_reg ? ram_q_reg : 8'd0;
                out_ra_reg  <= res_ra_reg;
                out_err_reg <= res_err_reg;
            end
        end
    end

    assign read_data   = out_rd_reg;
    assign rom_address = out_ra_reg;
    assign range_error = out_err_reg;

    a_rom_bank_low_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank_reg[4:0] != 5'd0)
        else $error("low rom bank bits reached zero");

    a_failed_read_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !rd_ok_reg) |=> out_rd_reg == 8'd0)
        else $error("read data not zero without a ram read");

    a_bad_ctrl_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && op_reg == OP_CTRL_WR && addr_reg[15])
        |=> $stable(rom_bank_reg) && $stable(ram_bank_reg) && $stable(banking_mode_reg))
        else $error("control write above rom area changed banking state");

endmodule
